@@ rtl/nla_pkg.sv @@
// nla_pkg: shared types and constants of the nearest landmark association block
// holds transaction structs, status codes, table entry layout and scan state type
// no dependencies
package nla_pkg;

  localparam int unsigned MaxLandmarks = 64;
  localparam int unsigned IdxW         = $clog2(MaxLandmarks);
  localparam int unsigned CntW         = $clog2(MaxLandmarks + 1);
  localparam int unsigned CoordW       = 24;
  localparam int unsigned IdentW       = 16;
  localparam int unsigned DiffW        = CoordW + 1;
  localparam int unsigned DistW        = 50;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ASSOC = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] STAT_ASSOCIATED = 3'd0;
  localparam logic [2:0] STAT_EMPTY      = 3'd1;
  localparam logic [2:0] STAT_LOADED     = 3'd2;
  localparam logic [2:0] STAT_FULL       = 3'd3;
  localparam logic [2:0] STAT_CLEARED    = 3'd4;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic [IdentW-1:0]        lm_id;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [IdentW-1:0] nearest_id;
    logic [DistW-1:0]  nearest_dist_sq;
  } out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [IdentW-1:0]        ident;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [IdentW-1:0] ident;
    logic [DistW-1:0]  dist_sq;
  } dist_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

endpackage

@@ rtl/nla_table.sv @@
// nla_table: landmark table memory, one write port and one registered read port
// entries are x, y and id packed as nla_pkg::entry_t
// depends on nla_pkg
module nla_table (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [nla_pkg::IdxW-1:0]  waddr_i,
  input  nla_pkg::entry_t           wdata_i,
  input  logic                      re_i,
  input  logic [nla_pkg::IdxW-1:0]  raddr_i,
  output nla_pkg::entry_t           rdata_o
);

  nla_pkg::entry_t mem [nla_pkg::MaxLandmarks];
  nla_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/nla_dist.sv @@
// nla_dist: three-stage squared distance pipeline, difference and magnitude,
// squaring, sum; the entry id rides along with each valid
// depends on nla_pkg
module nla_dist (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [nla_pkg::CoordW-1:0] px_i,
  input  logic signed [nla_pkg::CoordW-1:0] py_i,
  input  nla_pkg::entry_t                  entry_i,
  output nla_pkg::dist_res_t               res_o,
  output logic                             busy_o
);

  logic                             v1_q, v2_q, v3_q;
  logic [nla_pkg::IdentW-1:0]       id1_q, id2_q, id3_q;
  logic signed [nla_pkg::DiffW-1:0] dx, dy;
  logic [nla_pkg::DiffW-1:0]        ax_d, ay_d, ax_q, ay_q;
  logic [nla_pkg::DistW-1:0]        sx_d, sy_d, sx_q, sy_q, sum_q;

  always_comb begin
    dx   = nla_pkg::DiffW'(px_i) - nla_pkg::DiffW'(entry_i.x);
    dy   = nla_pkg::DiffW'(py_i) - nla_pkg::DiffW'(entry_i.y);
    ax_d = dx[nla_pkg::DiffW-1] ? nla_pkg::DiffW'(-dx) : nla_pkg::DiffW'(dx);
    ay_d = dy[nla_pkg::DiffW-1] ? nla_pkg::DiffW'(-dy) : nla_pkg::DiffW'(dy);
    sx_d = ax_q * ax_q;
    sy_d = ay_q * ay_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= ax_d;
    ay_q  <= ay_d;
    id1_q <= entry_i.ident;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
    id2_q <= id1_q;
    sum_q <= sx_q + sy_q;
    id3_q <= id2_q;
  end

  assign res_o.valid   = v3_q;
  assign res_o.ident   = id3_q;
  assign res_o.dist_sq = sum_q;
  assign busy_o        = v1_q | v2_q | v3_q;

endmodule

@@ rtl/nearest_landmark_association.sv @@
// nearest_landmark_association: top level with transaction control, table scan
// and nearest entry selection
// depends on nla_pkg, nla_table, nla_dist
//
// usage
//   input channel: in_valid_i / in_stall_o with in_data_i (op, point, id)
//   output channel: out_valid_o / out_stall_i with out_data_o (status, id, dist)
//   one result transaction per input transaction; op code 3 is dropped silently
// transaction flow
//   load, clear and query on an empty table: IDLE goes straight to RESULT, which
//   copies the result into the output register
//   query: SCAN reads the table through its single read port, one entry per cycle,
//   followed by the drain of the distance pipeline, then RESULT
//   one transaction is worked on at a time; the next input is taken while
//   a finished result still sits in the output register
// reset
//   the table is empty and no result is pending; table contents are not cleared
// stall
//   a stalled result holds in the output register; the block finishes the next
//   transaction and then waits, stalling its input, until the register frees
module nearest_landmark_association (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  nla_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output nla_pkg::out_t out_data_o
);

  nla_pkg::state_e                  state_q, state_d;
  logic [nla_pkg::CntW-1:0]         count_q;
  logic [nla_pkg::CntW-1:0]         addr_q;
  logic signed [nla_pkg::CoordW-1:0] px_q, py_q;
  nla_pkg::out_t                    res_q, out_q;
  logic                             out_valid_q;
  logic                             rd_valid_q;
  logic                             best_vld_q;
  logic [nla_pkg::DistW-1:0]        best_d_q;
  logic [nla_pkg::IdentW-1:0]       best_id_q;

  logic               accept, out_free, tbl_we, rd_en, dist_busy, not_full;
  nla_pkg::entry_t    wr_entry, rd_entry;
  nla_pkg::dist_res_t dist_res;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign not_full = count_q < nla_pkg::CntW'(nla_pkg::MaxLandmarks);

  assign wr_entry.x     = in_data_i.point_x;
  assign wr_entry.y     = in_data_i.point_y;
  assign wr_entry.ident = in_data_i.lm_id;

  always_comb begin
    state_d    = state_q;
    tbl_we     = 1'b0;
    rd_en      = 1'b0;
    in_stall_o = (state_q != nla_pkg::S_IDLE);
    case (state_q)
      nla_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data_i.op)
            nla_pkg::OP_LOAD: begin
              tbl_we  = not_full;
              state_d = nla_pkg::S_RESULT;
            end
            nla_pkg::OP_ASSOC: begin
              state_d = (count_q == '0) ? nla_pkg::S_RESULT : nla_pkg::S_SCAN;
            end
            nla_pkg::OP_CLEAR: begin
              state_d = nla_pkg::S_RESULT;
            end
            default: begin
              state_d = nla_pkg::S_IDLE;
            end
          endcase
        end
      end
      nla_pkg::S_SCAN: begin
        rd_en = addr_q < count_q;
        if (addr_q == count_q && !rd_valid_q && !dist_busy) begin
          state_d = nla_pkg::S_RESULT;
        end
      end
      nla_pkg::S_RESULT: begin
        if (out_free) begin
          state_d = nla_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = nla_pkg::S_IDLE;
      end
    endcase
  end

  nla_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[nla_pkg::IdxW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (addr_q[nla_pkg::IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  nla_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_valid_q),
    .px_i    (px_q),
    .py_i    (py_q),
    .entry_i (rd_entry),
    .res_o   (dist_res),
    .busy_o  (dist_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nla_pkg::S_IDLE;
      count_q     <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
      best_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= rd_en;
      if (accept && in_data_i.op == nla_pkg::OP_LOAD && not_full) begin
        count_q <= count_q + nla_pkg::CntW'(1);
      end else if (accept && in_data_i.op == nla_pkg::OP_CLEAR) begin
        count_q <= '0;
      end
      if (accept && in_data_i.op == nla_pkg::OP_ASSOC) begin
        addr_q     <= '0;
        best_vld_q <= 1'b0;
      end else begin
        if (rd_en) begin
          addr_q <= addr_q + nla_pkg::CntW'(1);
        end
        if (dist_res.valid) begin
          best_vld_q <= 1'b1;
        end
      end
      if (state_q == nla_pkg::S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q                  <= in_data_i.point_x;
      py_q                  <= in_data_i.point_y;
      res_q.nearest_id      <= '0;
      res_q.nearest_dist_sq <= '0;
      case (in_data_i.op)
        nla_pkg::OP_LOAD:  res_q.status <= not_full ? nla_pkg::STAT_LOADED
                                                    : nla_pkg::STAT_FULL;
        nla_pkg::OP_ASSOC: res_q.status <= nla_pkg::STAT_EMPTY;
        default:           res_q.status <= nla_pkg::STAT_CLEARED;
      endcase
    end else if (state_q == nla_pkg::S_SCAN && state_d == nla_pkg::S_RESULT) begin
      res_q.status          <= nla_pkg::STAT_ASSOCIATED;
      res_q.nearest_id      <= best_id_q;
      res_q.nearest_dist_sq <= best_d_q;
    end
    if (dist_res.valid && (!best_vld_q || dist_res.dist_sq < best_d_q)) begin
      best_d_q  <= dist_res.dist_sq;
      best_id_q <= dist_res.ident;
    end
    if (state_q == nla_pkg::S_RESULT && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= nla_pkg::CntW'(nla_pkg::MaxLandmarks))
    else $error("entry count above table capacity");

  a_scan_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nla_pkg::S_SCAN |-> addr_q <= count_q)
    else $error("scan address past entry count");

  a_assoc_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nla_pkg::S_SCAN && state_d == nla_pkg::S_RESULT |-> best_vld_q)
    else $error("scan finished without a compared entry");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != nla_pkg::STAT_ASSOCIATED
    |-> out_data_o.nearest_id == '0 && out_data_o.nearest_dist_sq == '0)
    else $error("non-associated result carries id or distance");
`endif

endmodule
